/* rtl/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define CHK_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under reset.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rsi_pkg.sv */
// Package: widths, register indexes, pipeline sideband type and saturation helpers.
`default_nettype none
package rsi_pkg;
  localparam int W    = 32;
  localparam int F    = 16;
  localparam int SQ_N = W;
  localparam int DV_N = W + 1;
  localparam int RW   = W + 4;
  localparam int NW   = W + 2;
  localparam int MW   = NW + F;
  localparam int NST  = 5 + SQ_N + 1 + DV_N + 3;

  typedef enum logic [1:0] {
    REG_CX  = 2'd0,
    REG_CY  = 2'd1,
    REG_CZ  = 2'd2,
    REG_RAD = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][W-1:0] s;
    logic [2:0][W-1:0] d;
    logic [W-1:0]      a;
    logic [W-1:0]      h;
    logic              hit;
    logic              neg;
    logic              ovf;
  } side_t;

  function automatic logic signed [2*W:0] sx(input logic [W-1:0] x);
    return $signed({{(W+1){x[W-1]}}, x});
  endfunction

  function automatic logic [W-1:0] sat_w(input logic signed [2*W:0] v);
    logic signed [2*W:0] hi;
    logic signed [2*W:0] lo;
    hi = $signed({{(W+2){1'b0}}, {(W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[W-1:0];
    else if (v < lo) return lo[W-1:0];
    else return v[W-1:0];
  endfunction

  // floor(p / 2^F), saturated to a word
  function automatic logic [W-1:0] mulq_w(input logic [2*W-1:0] p);
    logic signed [2*W:0] e;
    e = $signed({p[2*W-1], p});
    return sat_w(e >>> F);
  endfunction
endpackage
`default_nettype wire

/* rtl/rsi_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
`default_nettype none
module rsi_sqrt_cell (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [rsi_pkg::RW-1:0]     rem_i,
  input  wire logic [rsi_pkg::W-1:0]      root_i,
  input  wire logic [2*rsi_pkg::W-1:0]    rad_i,
  output      logic [rsi_pkg::RW-1:0]     rem_o,
  output      logic [rsi_pkg::W-1:0]      root_o,
  output      logic [2*rsi_pkg::W-1:0]    rad_o
);
  import rsi_pkg::*;

  logic [RW-1:0] r2, trial, rem_d;
  logic          ge;

  always_comb begin
    r2    = {rem_i[RW-3:0], rad_i[2*W-1:2*W-2]};
    trial = RW'({root_i, 2'b01});
    ge    = r2 >= trial;
    rem_d = ge ? r2 - trial : r2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= {root_i[W-2:0], ge};
      rad_o  <= {rad_i[2*W-3:0], 2'b00};
    end
  end
endmodule
`default_nettype wire

/* rtl/rsi_div_cell.sv */
// One quotient-bit cell of the pipelined restoring divider.
`default_nettype none
module rsi_div_cell (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [rsi_pkg::W-1:0]      rem_i,
  input  wire logic [rsi_pkg::DV_N-1:0]   dvd_i,
  input  wire logic [rsi_pkg::DV_N-1:0]   quo_i,
  input  wire logic [rsi_pkg::W-1:0]      dvs_i,
  output      logic [rsi_pkg::W-1:0]      rem_o,
  output      logic [rsi_pkg::DV_N-1:0]   dvd_o,
  output      logic [rsi_pkg::DV_N-1:0]   quo_o,
  output      logic [rsi_pkg::W-1:0]      dvs_o
);
  import rsi_pkg::*;

  logic [W:0] r2, rd;
  logic       ge;

  always_comb begin
    r2 = {rem_i, dvd_i[DV_N-1]};
    ge = r2 >= {1'b0, dvs_i};
    rd = ge ? r2 - {1'b0, dvs_i} : r2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rd[W-1:0];
      dvd_o <= {dvd_i[DV_N-2:0], 1'b0};
      quo_o <= {quo_i[DV_N-2:0], ge};
      dvs_o <= dvs_i;
    end
  end
endmodule
`default_nettype wire

/* rtl/ray_sphere_intersect.sv */
// Top level: fixed-point ray against sphere intersection pipeline.
// Usage:
//   Rays enter on the s_axis channel, one per transfer: start x/y/z then
//   direction x/y/z, signed Q16.16. Results leave on m_axis: tuser is the hit
//   flag, tdata holds t_near and the hit point; all zero on a miss.
//   Sphere center and radius are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   (0..2 center x/y/z, 3 radius); write only while no ray is in flight.
//   Pipeline stages: dot products and discriminant (5 stages), a row of
//   32 square-root cells, one setup stage, a row of 33 divider cells, then
//   t, t*D and the point sum with the output register.
//   Throughput is one ray per cycle while en is high; all cells share en.
//   The whole pipe advances together: while a result waits with m_axis_tready
//   low, the pipe holds and s_axis_tready drops; a ray is still accepted in
//   the cycle the waiting result is taken.
//   Reset clears all valid bits and sets the center to 0, radius to 1.0.
`default_nettype none
module ray_sphere_intersect (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z
  input  wire logic [6*rsi_pkg::W-1:0] s_axis_tdata,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // t_near, point_x, point_y, point_z
  output      logic [4*rsi_pkg::W-1:0] m_axis_tdata,
  // hit
  output      logic                   m_axis_tuser,
  input  wire logic                   cfg_we_i,
  input  wire rsi_pkg::reg_idx_e      cfg_idx_i,
  input  wire logic [rsi_pkg::W-1:0]  cfg_data_i
);
  import rsi_pkg::*;

  logic [2:0][W-1:0] cen_q;
  logic [W-2:0]      rad_q;
  logic [NST-1:0]    vld_q;
  logic              en;

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
      rad_q <= (W-1)'(1) << F;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CX:  cen_q[0] <= cfg_data_i;
          REG_CY:  cen_q[1] <= cfg_data_i;
          REG_CZ:  cen_q[2] <= cfg_data_i;
          REG_RAD: rad_q    <= cfg_data_i[W-2:0];
          default: ;
        endcase
      end
      if (en) vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // stage A: L = S - C
  side_t             a_q;
  logic [2:0][W-1:0] a_l_q;
  // stage B: raw products
  side_t             b_q;
  logic [2:0][2*W-1:0] b_dd_q, b_ld_q, b_ll_q;
  logic [2*W-1:0]    b_rr_q;
  // stage C: a, h, c
  side_t             c_q;
  logic [W-1:0]      c_c_q;
  // stage D: h*h, a*c
  side_t             d_q;
  logic [2*W-1:0]    d_hh_q, d_ac_q;
  // stage E: discriminant
  side_t             e_q;
  logic [2*W-1:0]    e_rad_q;
  side_t             c_d, e_d;

  always_comb begin
    c_d   = b_q;
    c_d.a = sat_w(sx(mulq_w(b_dd_q[0])) + sx(mulq_w(b_dd_q[1])) + sx(mulq_w(b_dd_q[2])));
    c_d.h = sat_w(sx(mulq_w(b_ld_q[0])) + sx(mulq_w(b_ld_q[1])) + sx(mulq_w(b_ld_q[2])));
    e_d     = d_q;
    e_d.hit = ($signed(d_q.a) > 0) &&
              !(($signed({d_hh_q[2*W-1], d_hh_q}) - $signed({d_ac_q[2*W-1], d_ac_q}))
                < 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_q.s[i] <= s_axis_tdata[i*W +: W];
        a_q.d[i] <= s_axis_tdata[(3+i)*W +: W];
        a_l_q[i] <= sat_w(sx(s_axis_tdata[i*W +: W]) - sx(cen_q[i]));
      end
      a_q.a   <= '0;
      a_q.h   <= '0;
      a_q.hit <= 1'b0;
      a_q.neg <= 1'b0;
      a_q.ovf <= 1'b0;

      b_q <= a_q;
      for (int i = 0; i < 3; i++) begin
        b_dd_q[i] <= $signed(a_q.d[i]) * $signed(a_q.d[i]);
        b_ld_q[i] <= $signed(a_l_q[i]) * $signed(a_q.d[i]);
        b_ll_q[i] <= $signed(a_l_q[i]) * $signed(a_l_q[i]);
      end
      b_rr_q <= (2*W)'(rad_q) * (2*W)'(rad_q);

      c_q   <= c_d;
      c_c_q <= sat_w(sx(mulq_w(b_ll_q[0])) + sx(mulq_w(b_ll_q[1])) + sx(mulq_w(b_ll_q[2]))
                     - sx(mulq_w(b_rr_q)));

      d_q    <= c_q;
      d_hh_q <= $signed(c_q.h) * $signed(c_q.h);
      d_ac_q <= $signed(c_q.a) * $signed(c_c_q);

      e_q     <= e_d;
      e_rad_q <= d_hh_q - d_ac_q;
    end
  end

  // square-root row
  logic [RW-1:0]   sq_rem  [SQ_N+1];
  logic [W-1:0]    sq_root [SQ_N+1];
  logic [2*W-1:0]  sq_rad  [SQ_N+1];
  side_t           sq_sd_q [SQ_N];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = e_rad_q;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    rsi_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_sd_q[0] <= e_q;
      for (int k = 1; k < SQ_N; k++) sq_sd_q[k] <= sq_sd_q[k-1];
    end
  end

  // stage F: numerator, magnitude, overflow check
  side_t             f_q;
  logic [W-1:0]      f_rem_q;
  logic [DV_N-1:0]   f_dvd_q;
  logic signed [NW-1:0] num;
  logic [NW-1:0]     mag;
  logic [MW-1:0]     dvd;
  logic [W-1:0]      dvd_hi;
  side_t             f_d;

  always_comb begin
    num    = -$signed({{2{sq_sd_q[SQ_N-1].h[W-1]}}, sq_sd_q[SQ_N-1].h})
             - $signed({2'b00, sq_root[SQ_N]});
    mag    = num[NW-1] ? NW'(-num) : NW'(num);
    dvd    = {mag, {F{1'b0}}};
    dvd_hi = W'(dvd[MW-1:DV_N]);
    f_d     = sq_sd_q[SQ_N-1];
    f_d.neg = num[NW-1];
    f_d.ovf = dvd_hi >= sq_sd_q[SQ_N-1].a;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q     <= f_d;
      f_rem_q <= dvd_hi;
      f_dvd_q <= dvd[DV_N-1:0];
    end
  end

  // divider row
  logic [W-1:0]    dv_rem [DV_N+1];
  logic [DV_N-1:0] dv_dvd [DV_N+1];
  logic [DV_N-1:0] dv_quo [DV_N+1];
  logic [W-1:0]    dv_dvs [DV_N+1];
  side_t           dv_sd_q [DV_N];

  assign dv_rem[0] = f_rem_q;
  assign dv_dvd[0] = f_dvd_q;
  assign dv_quo[0] = '0;
  assign dv_dvs[0] = f_q.a;

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    rsi_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (dv_rem[k]),
      .dvd_i (dv_dvd[k]),
      .quo_i (dv_quo[k]),
      .dvs_i (dv_dvs[k]),
      .rem_o (dv_rem[k+1]),
      .dvd_o (dv_dvd[k+1]),
      .quo_o (dv_quo[k+1]),
      .dvs_o (dv_dvs[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sd_q[0] <= f_q;
      for (int k = 1; k < DV_N; k++) dv_sd_q[k] <= dv_sd_q[k-1];
    end
  end

  // stage G: saturate t, stage H: t*D, stage I: point and output register
  side_t           g_q, h_q;
  logic [W-1:0]    g_t_q, h_t_q;
  logic [2:0][2*W-1:0] h_p_q;
  logic [DV_N-1:0] cap, qs;
  side_t           gs;
  logic [2:0][W-1:0] pt;

  always_comb begin
    gs  = dv_sd_q[DV_N-1];
    cap = {1'b0, gs.neg, {(W-1){~gs.neg}}};
    qs  = (gs.ovf || dv_quo[DV_N] > cap) ? cap : dv_quo[DV_N];
    for (int i = 0; i < 3; i++) pt[i] = sat_w(sx(h_q.s[i]) + sx(mulq_w(h_p_q[i])));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q   <= gs;
      g_t_q <= gs.neg ? -qs[W-1:0] : qs[W-1:0];

      h_q   <= g_q;
      h_t_q <= g_t_q;
      for (int i = 0; i < 3; i++) h_p_q[i] <= $signed(g_t_q) * $signed(g_q.d[i]);

      m_axis_tuser <= h_q.hit;
      m_axis_tdata <= h_q.hit ? {pt[2], pt[1], pt[0], h_t_q} : '0;
    end
  end
endmodule
`default_nettype wire

/* rtl/rsi_checker.sv */
// Port-level checker for the ray/sphere pipeline, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rsi_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tready,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [4*rsi_pkg::W-1:0] m_axis_tdata,
  input wire logic                    m_axis_tuser
);
  import rsi_pkg::*;

  `CHK_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CHK_IMPLY(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  `CHK_IMPLY(a_ready, clk_i, rst_ni, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
